>>> hw/rtl/brc_pkg.sv
// ----------------------------------------------------------------------------
// brc_pkg
// Shared types and constants of the byte rotor cipher: symbol width, rotor
// count, request codes, stage modes and the item token that walks the pipe.
// ----------------------------------------------------------------------------
package brc_pkg;

  localparam int SYM_W    = 8;
  localparam int SYM_N    = 1 << SYM_W;
  localparam int ROTOR_N  = 3;
  localparam int ROT_W    = (ROTOR_N > 1) ? $clog2(ROTOR_N) : 1;
  localparam int SEL_W    = 2;
  localparam int STAGE_N  = 2 * ROTOR_N + 1;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [ROTOR_N-1:0][SYM_W-1:0] off_vec_t;

  // request codes carried by req_type
  typedef enum logic [1:0] {
    REQ_LOAD_ROTOR = 2'd0,
    REQ_LOAD_REFL  = 2'd1,
    REQ_RESTART    = 2'd2,
    REQ_ENCIPHER   = 2'd3
  } req_t;

  // what one table stage does with its memory
  typedef enum logic [1:0] {
    STG_FWD  = 2'd0,
    STG_REFL = 2'd1,
    STG_INV  = 2'd2
  } stage_mode_t;

  // one item as it travels through the table stages
  typedef struct packed {
    logic             valid;
    req_t             kind;
    logic [SEL_W-1:0] sel;
    sym_t             idx;
    sym_t             val;
    sym_t             x;
    off_vec_t         off;
  } tok_t;

endpackage

>>> hw/rtl/brc_in_if.sv
// ----------------------------------------------------------------------------
// brc_in_if
// Request channel: valid/ready handshake with load, restart and data fields.
// ----------------------------------------------------------------------------
interface brc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] rotor_select;
  logic [7:0] entry_index;
  logic [7:0] entry_value;
  logic [7:0] data_byte;

  modport source (
    output valid, req_type, rotor_select, entry_index, entry_value, data_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, rotor_select, entry_index, entry_value, data_byte,
    output ready
  );
endinterface

>>> hw/rtl/brc_out_if.sv
// ----------------------------------------------------------------------------
// brc_out_if
// Result channel: valid/ready handshake carrying one cipher byte.
// ----------------------------------------------------------------------------
interface brc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;

  modport source (
    output valid, cipher_byte,
    input  ready
  );
  modport sink (
    input  valid, cipher_byte,
    output ready
  );
endinterface

>>> hw/rtl/brc_ram.sv
// ----------------------------------------------------------------------------
// brc_ram
// Generic single-write, single-read synchronous RAM with registered read
// data and a read enable that holds the output during a stall.
// ----------------------------------------------------------------------------
module brc_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/brc_stage.sv
// ----------------------------------------------------------------------------
// brc_stage
// One table stage of the cipher pipe. Holds one table memory (forward rotor,
// reflector or inverse rotor), writes it when a matching load item passes,
// and looks up the running symbol of an encipher item.
// ----------------------------------------------------------------------------
module brc_stage
  import brc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  stage_mode_t mode,
  input  logic [ROT_W-1:0] rotor,
  input  tok_t        tok_in,
  output tok_t        tok_out
);

  tok_t tok_r;
  logic we;
  sym_t waddr;
  sym_t wdata;
  sym_t raddr;
  sym_t rdata;
  sym_t off_in;
  sym_t off_out;

  assign off_in  = tok_in.off[rotor];
  assign off_out = tok_r.off[rotor];

  // write and lookup addresses per stage kind
  always_comb begin
    we    = 1'b0;
    waddr = tok_in.idx;
    wdata = tok_in.val;
    raddr = tok_in.x;
    unique case (mode)
      STG_FWD: begin
        we    = tok_in.valid && (tok_in.kind == REQ_LOAD_ROTOR)
                && (tok_in.sel == SEL_W'(rotor));
        raddr = tok_in.x - off_in;
      end
      STG_REFL: begin
        we    = tok_in.valid && (tok_in.kind == REQ_LOAD_REFL);
      end
      STG_INV: begin
        we    = tok_in.valid && (tok_in.kind == REQ_LOAD_ROTOR)
                && (tok_in.sel == SEL_W'(rotor));
        waddr = tok_in.val;
        wdata = tok_in.idx;
      end
      default: begin
        we    = 1'b0;
      end
    endcase
  end

  brc_ram #(
    .DEPTH (SYM_N),
    .WIDTH (SYM_W)
  ) u_ram (
    .clk   (clk),
    .we    (we && adv),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (raddr),
    .rdata (rdata)
  );

  // item register, in step with the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_in;
    end
  end

  // inverse lookup turns back by the rotor offset
  always_comb begin
    tok_out = tok_r;
    if (mode == STG_INV) begin
      tok_out.x = rdata + off_out;
    end else begin
      tok_out.x = rdata;
    end
  end

endmodule

>>> hw/rtl/byte_rotor_cipher.sv
// ----------------------------------------------------------------------------
// byte_rotor_cipher
// Byte-wide rotor cipher: forward through each rotor, reflector, back
// through each rotor, with odometer stepping of the rotor offsets.
// ----------------------------------------------------------------------------
// Pipe: an item passes the 7 table stages, the first reading at the accepting
// edge, then the output register.
// Throughput: one item per cycle; the whole pipe holds while a result waits.
// Reset: rotor offsets zero, pipe and output empty; tables hold unknown data
// until loaded and get no clearing pass.
module byte_rotor_cipher
  import brc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  brc_in_if.sink        in_ch,
  brc_out_if.source     out_ch
);

  tok_t     chain [STAGE_N+1];
  off_vec_t off_r;
  off_vec_t off_nxt;
  logic     adv;
  logic     accept;
  logic     out_valid_r;
  sym_t     out_byte_r;
  req_t     in_kind;
  logic [ROTOR_N-1:0] step;

  // pipe moves whenever the output register is free or being emptied
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;
  assign in_kind     = req_t'(in_ch.req_type);

  // entry item, carrying the offsets before this item steps them
  always_comb begin
    chain[0].valid = in_ch.valid;
    chain[0].kind  = in_kind;
    chain[0].sel   = in_ch.rotor_select;
    chain[0].idx   = in_ch.entry_index;
    chain[0].val   = in_ch.entry_value;
    chain[0].x     = in_ch.data_byte;
    chain[0].off   = off_r;
  end

  // odometer stepping of the offsets
  always_comb begin
    off_nxt = off_r;
    step    = '0;
    step[0] = 1'b1;
    for (int r = 1; r < ROTOR_N; r++) begin
      step[r] = step[r-1] && (off_r[r-1] == sym_t'(SYM_N - 1));
    end
    if (in_kind == REQ_RESTART) begin
      off_nxt = '0;
    end else if (in_kind == REQ_ENCIPHER) begin
      for (int r = 0; r < ROTOR_N; r++) begin
        if (step[r]) begin
          off_nxt[r] = off_r[r] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else if (accept) begin
      off_r <= off_nxt;
    end
  end

  // table stages: forward rotors, reflector, inverse rotors in reverse
  for (genvar i = 0; i < STAGE_N; i++) begin : g_stage
    stage_mode_t     mode_c;
    logic [ROT_W-1:0] rotor_c;

    if (i < ROTOR_N) begin : g_fwd
      assign mode_c  = STG_FWD;
      assign rotor_c = ROT_W'(i);
    end else if (i == ROTOR_N) begin : g_refl
      assign mode_c  = STG_REFL;
      assign rotor_c = '0;
    end else begin : g_inv
      assign mode_c  = STG_INV;
      assign rotor_c = ROT_W'(STAGE_N - 1 - i);
    end

    brc_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .mode    (mode_c),
      .rotor   (rotor_c),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // output register, marked valid only by encipher items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[STAGE_N].valid && (chain[STAGE_N].kind == REQ_ENCIPHER);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= chain[STAGE_N].x;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cipher_byte = out_byte_r;

endmodule

>>> tb/sv/tb_byte_rotor_cipher.sv
// ----------------------------------------------------------------------------
// tb_byte_rotor_cipher
// Self-checking bench for the byte rotor cipher. Every table is loaded before
// the first byte is enciphered. A short table of hand-picked items comes
// first: identity rotors, an ignored load to a rotor that does not exist, a
// broken permutation and restarts. Random tables and a random mix of loads,
// restarts and bytes follow. A run of bytes then carries the odometer into
// the middle rotor. Each byte is checked against a typed expectation or an
// in-bench model of the rotors, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_byte_rotor_cipher
  import brc_pkg::*;
();

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 24;
  localparam int MIX_ITEMS    = 300;
  localparam int CARRY_RUN    = SYM_N + 16;
  localparam int IDLE_PCT     = 28;
  localparam int DIR_N        = 23;

  typedef struct packed {
    req_t       kind;
    logic [1:0] sel;
    sym_t       idx;
    sym_t       val;
    sym_t       data;
    logic       typed;
    sym_t       want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  brc_in_if  in_ch ();
  brc_out_if out_ch ();

  byte_rotor_cipher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // cipher state tracked on the bench side
  sym_t rotor_fwd [ROTOR_N][SYM_N];
  sym_t rotor_inv [ROTOR_N][SYM_N];
  sym_t refl_map [SYM_N];
  sym_t rotor_pos [ROTOR_N];

  sym_t cipher_q [$];
  int   fail_count = 0;
  int   checked_count = 0;
  int   kind_count [4] = '{0, 0, 0, 0};
  int   in_idle_pct = IDLE_PCT;
  int   out_idle_pct = IDLE_PCT;
  int   quiet_cycles = 0;

  // hand-picked items; typed expectations hold with identity rotors
  stim_row_t dir_rows [DIR_N] = '{
    '{REQ_ENCIPHER,   2'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00},
    '{REQ_ENCIPHER,   2'd0, 8'h00, 8'h00, 8'hff, 1'b1, 8'hff},
    '{REQ_ENCIPHER,   2'd0, 8'h00, 8'h00, 8'ha5, 1'b1, 8'ha5},
    '{REQ_LOAD_ROTOR, 2'd3, 8'h00, 8'hff, 8'h00, 1'b0, 8'h00},
    '{REQ_ENCIPHER,   2'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00},
    '{REQ_LOAD_REFL,  2'd0, 8'h00, 8'hff, 8'h00, 1'b0, 8'h00},
    '{REQ_LOAD_REFL,  2'd0, 8'hff, 8'h00, 8'h00, 1'b0, 8'h00},
    '{REQ_RESTART,    2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
    '{REQ_ENCIPHER,   2'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'hff},
    '{REQ_ENCIPHER,   2'd0, 8'h00, 8'h00, 8'h01, 1'b0, 8'h00},
    '{REQ_LOAD_ROTOR, 2'd1, 8'h07, 8'h09, 8'h00, 1'b0, 8'h00},
    '{REQ_ENCIPHER,   2'd0, 8'h00, 8'h00, 8'h07, 1'b0, 8'h00},
    '{REQ_ENCIPHER,   2'd0, 8'h00, 8'h00, 8'h09, 1'b0, 8'h00},
    '{REQ_LOAD_ROTOR, 2'd1, 8'h07, 8'h07, 8'h00, 1'b0, 8'h00},
    '{REQ_LOAD_ROTOR, 2'd1, 8'h09, 8'h09, 8'h00, 1'b0, 8'h00},
    '{REQ_LOAD_REFL,  2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
    '{REQ_LOAD_REFL,  2'd0, 8'hff, 8'hff, 8'h00, 1'b0, 8'h00},
    '{REQ_RESTART,    2'd3, 8'hff, 8'hff, 8'hff, 1'b0, 8'h00},
    '{REQ_ENCIPHER,   2'd3, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff},
    '{REQ_LOAD_ROTOR, 2'd2, 8'hff, 8'h00, 8'h00, 1'b0, 8'h00},
    '{REQ_LOAD_ROTOR, 2'd2, 8'h00, 8'hff, 8'h00, 1'b0, 8'h00},
    '{REQ_ENCIPHER,   2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
    '{REQ_ENCIPHER,   2'd0, 8'h00, 8'h00, 8'hff, 1'b0, 8'h00}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one byte through the rotors, reflector and back
  function automatic sym_t cipher_of(input sym_t b);
    sym_t x;
    x = b;
    for (int r = 0; r < ROTOR_N; r++) x = rotor_fwd[r][sym_t'(x - rotor_pos[r])];
    x = refl_map[x];
    for (int r = ROTOR_N - 1; r >= 0; r--) x = sym_t'(rotor_inv[r][x] + rotor_pos[r]);
    return x;
  endfunction

  // odometer step after each byte
  function automatic void step_rotors();
    bit carry;
    carry = 1'b1;
    for (int r = 0; r < ROTOR_N; r++) begin
      if (carry) begin
        rotor_pos[r] = sym_t'(rotor_pos[r] + 1);
        carry = (rotor_pos[r] == '0);
      end
    end
  endfunction

  // apply an accepted item to the tracked state, queue its cipher byte
  function automatic void track_item(input stim_row_t it);
    kind_count[it.kind]++;
    case (it.kind)
      REQ_LOAD_ROTOR: begin
        if (it.sel < ROTOR_N) begin
          rotor_fwd[it.sel][it.idx] = it.val;
          rotor_inv[it.sel][it.val] = it.idx;
        end
      end
      REQ_LOAD_REFL: refl_map[it.idx] = it.val;
      REQ_RESTART: begin
        foreach (rotor_pos[r]) rotor_pos[r] = '0;
      end
      default: begin
        cipher_q.push_back(it.typed ? it.want : cipher_of(it.data));
        step_rotors();
      end
    endcase
  endfunction

  // item of the given kind with every other field random
  function automatic stim_row_t any_row(input req_t k);
    stim_row_t it;
    it.kind  = k;
    it.sel   = 2'($urandom_range(0, 3));
    it.idx   = sym_t'($urandom_range(0, 255));
    it.val   = sym_t'($urandom_range(0, 255));
    it.data  = sym_t'($urandom_range(0, 255));
    it.typed = 1'b0;
    it.want  = '0;
    return it;
  endfunction

  // drive one item at the falling edge, hold until it is taken
  task automatic send_item(input stim_row_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= it.kind;
    in_ch.rotor_select <= it.sel;
    in_ch.entry_index  <= it.idx;
    in_ch.entry_value  <= it.val;
    in_ch.data_byte    <= it.data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_item(it);
  endtask

  // fill all rotors and the reflector, identity or random
  task automatic load_tables(input bit scramble);
    sym_t perm [SYM_N];
    sym_t pair [SYM_N];
    sym_t t;
    int j;
    stim_row_t it;
    for (int r = 0; r <= ROTOR_N; r++) begin
      foreach (perm[i]) perm[i] = sym_t'(i);
      if (scramble) begin
        for (int i = SYM_N - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = perm[i];
          perm[i] = perm[j];
          perm[j] = t;
        end
      end
      // the reflector becomes an involution built from shuffled pairs
      if (scramble && r == ROTOR_N) begin
        for (int k = 0; k < SYM_N; k += 2) begin
          pair[perm[k]] = perm[k + 1];
          pair[perm[k + 1]] = perm[k];
        end
        perm = pair;
      end
      for (int i = 0; i < SYM_N; i++) begin
        it = any_row(r == ROTOR_N ? REQ_LOAD_REFL : REQ_LOAD_ROTOR);
        if (r < ROTOR_N) it.sel = 2'(r);
        it.idx = sym_t'(i);
        it.val = perm[i];
        send_item(it);
      end
    end
  endtask

  // result side: random back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // compare each taken cipher byte with the oldest expectation
  always @(posedge clk) begin : check_results
    sym_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cipher_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected cipher byte %02h at %0t", out_ch.cipher_byte, $realtime);
      end else begin
        want = cipher_q.pop_front();
        checked_count++;
        if (out_ch.cipher_byte !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("cipher byte mismatch: expected %02h, got %02h at %0t",
                     want, out_ch.cipher_byte, $realtime);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("tb_byte_rotor_cipher failed");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    stim_row_t it;
    int n;
    int pick;
    int r;
    sym_t a;
    sym_t b;
    sym_t va;
    sym_t vb;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_LOAD_ROTOR;
    in_ch.rotor_select = '0;
    in_ch.entry_index  = '0;
    in_ch.entry_value  = '0;
    in_ch.data_byte    = '0;
    out_ch.ready       = 1'b0;
    foreach (rotor_pos[k]) rotor_pos[k] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // identity tables, then the hand-picked items
    load_tables(1'b0);
    foreach (dir_rows[k]) send_item(dir_rows[k]);

    // random tables, then a random mix of items
    load_tables(1'b1);
    n = 0;
    while (n < MIX_ITEMS) begin
      in_idle_pct  = (n >= 100 && n < 250) ? 0 : IDLE_PCT;
      out_idle_pct = in_idle_pct;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_item(any_row(REQ_ENCIPHER));
        n++;
      end else if (pick < 70) begin
        // swap two entries of one rotor so it stays a permutation
        r  = $urandom_range(0, ROTOR_N - 1);
        a  = sym_t'($urandom_range(0, 255));
        b  = sym_t'($urandom_range(0, 255));
        va = rotor_fwd[r][a];
        vb = rotor_fwd[r][b];
        it = any_row(REQ_LOAD_ROTOR);
        it.sel = 2'(r);
        it.idx = a;
        it.val = vb;
        send_item(it);
        it.idx = b;
        it.val = va;
        send_item(it);
        n += 2;
      end else if (pick < 80) begin
        // lone load, may break a permutation or hit a missing rotor
        send_item(any_row(REQ_LOAD_ROTOR));
        n++;
      end else if (pick < 92) begin
        send_item(any_row(REQ_LOAD_REFL));
        n++;
      end else begin
        send_item(any_row(REQ_RESTART));
        n++;
      end
    end

    // byte run from zero offsets: carries reach the middle rotor
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
    send_item(any_row(REQ_RESTART));
    for (int k = 0; k < CARRY_RUN; k++) send_item(any_row(REQ_ENCIPHER));

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("items: %0d rotor loads, %0d reflector loads, %0d restarts, %0d bytes",
             kind_count[REQ_LOAD_ROTOR], kind_count[REQ_LOAD_REFL],
             kind_count[REQ_RESTART], kind_count[REQ_ENCIPHER]);
    $display("%0d cipher bytes checked, rotor offsets ended at %0d/%0d/%0d",
             checked_count, rotor_pos[0], rotor_pos[1], rotor_pos[2]);
    if (fail_count == 0 && cipher_q.size() == 0) begin
      $display("tb_byte_rotor_cipher passed");
    end else begin
      $display("%0d failures, %0d bytes still expected", fail_count, cipher_q.size());
      $display("tb_byte_rotor_cipher failed");
    end
    $finish;
  end

endmodule
